### rtl/scsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsl_pkg
// Shared constants, types and helper functions of the supersequence length
// unit.
// ----------------------------------------------------------------------------
package scsl_pkg;

    localparam int MAX_LEN     = 128;
    localparam int SYMBOL_BITS = 8;

    localparam int IN_SYM_W  = 8;
    localparam int SUPER_W   = 9;
    localparam int LCS_W     = 8;
    localparam int SUPER_MAX = 511;
    localparam int LCS_MAX   = 255;

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    typedef logic [CNT_W-1:0]       t_count;
    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [SYMBOL_BITS-1:0] t_sym;

    typedef struct packed {
        logic  push;
        logic  clear;
        logic  calc;
        logic  first_row;
        logic  finish;
        t_addr row;
        t_addr col;
    } t_cmd;

    typedef struct packed {
        t_count m;
        t_count n;
        logic   out_busy;
    } t_status;

    function automatic logic [SUPER_W-1:0] sat_super(input logic [CNT_W:0] total);
        if (32'(total) > SUPER_MAX) begin
            return SUPER_W'(SUPER_MAX);
        end
        return SUPER_W'(total);
    endfunction

    function automatic logic [LCS_W-1:0] sat_lcs(input t_count lcs);
        if (32'(lcs) > LCS_MAX) begin
            return LCS_W'(LCS_MAX);
        end
        return LCS_W'(lcs);
    endfunction

endpackage

### rtl/scs_length_via_lcs_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_length_via_lcs_unit
// Shortest common supersequence length of two loaded strings through an LCS
// table walk.
// ----------------------------------------------------------------------------
// Each symbol word loads as it is taken. The final word of the second string
// starts the table walk, which updates one LCS cell per cycle within a row
// through the row buffer RAM: a setup state, per row a fetch state, n cell
// updates and a drain state, then a finish state that captures the result.
// No word is accepted during the walk. Symbols beyond the store depth are
// dropped and reported through o_overflowed. A finished result waits in an
// output register while loading of the next strings goes on; only the next
// final word of a second string waits until it is taken.
module scs_length_via_lcs_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [scsl_pkg::IN_SYM_W-1:0] i_symbol,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [scsl_pkg::SUPER_W-1:0]  o_super_length,
    output logic [scsl_pkg::LCS_W-1:0]    o_lcs_length,
    output logic                          o_overflowed
);
    import scsl_pkg::*;

    t_cmd    cmd_bus;
    t_status status;

    scsl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_cmd     (i_cmd),
        .i_last    (i_last),
        .i_status  (status),
        .o_cmd_bus (cmd_bus)
    );

    scsl_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_bus      (cmd_bus),
        .o_status       (status),
        .i_cmd          (i_cmd),
        .i_symbol       (i_symbol),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_super_length (o_super_length),
        .o_lcs_length   (o_lcs_length),
        .o_overflowed   (o_overflowed)
    );

endmodule

### rtl/scsl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module scsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/scsl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsl_datapath
// Symbol stores, LCS row buffer, cell update and result register.
// ----------------------------------------------------------------------------
module scsl_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  scsl_pkg::t_cmd                 i_cmd_bus,
    output scsl_pkg::t_status              o_status,
    input  logic                           i_cmd,
    input  logic [scsl_pkg::IN_SYM_W-1:0]  i_symbol,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [scsl_pkg::SUPER_W-1:0]   o_super_length,
    output logic [scsl_pkg::LCS_W-1:0]     o_lcs_length,
    output logic                           o_overflowed
);
    import scsl_pkg::*;

    t_count r_m, n_m;
    t_count r_n, n_n;
    logic   r_ovf, n_ovf;
    t_count r_diag, n_diag;
    t_count r_left, n_left;
    logic   r_cell_v;
    t_addr  r_k_d;
    logic   r_out_valid, n_out_valid;
    logic [SUPER_W-1:0] r_super;
    logic [LCS_W-1:0]   r_lcs;
    logic               r_ovf_out;

    logic   a_full, b_full;
    logic   we_a, we_b;
    t_sym   sym_in;
    t_sym   a_rdata, b_rdata;
    t_count rb_rdata;
    t_count above, val;
    logic [CNT_W:0] total;

    assign sym_in = i_symbol[SYMBOL_BITS-1:0];
    assign a_full = (r_m == CNT_W'(MAX_LEN));
    assign b_full = (r_n == CNT_W'(MAX_LEN));
    assign we_a   = i_cmd_bus.push && !i_cmd && !a_full;
    assign we_b   = i_cmd_bus.push && i_cmd && !b_full;

    scsl_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_first_store (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_m[ADDR_W-1:0]),
        .i_wdata (sym_in),
        .i_raddr (i_cmd_bus.row),
        .o_rdata (a_rdata)
    );

    scsl_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_second_store (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_n[ADDR_W-1:0]),
        .i_wdata (sym_in),
        .i_raddr (i_cmd_bus.col),
        .o_rdata (b_rdata)
    );

    scsl_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_row_buffer (
        .i_clk   (i_clk),
        .i_we    (r_cell_v),
        .i_waddr (r_k_d),
        .i_wdata (val),
        .i_raddr (i_cmd_bus.col),
        .o_rdata (rb_rdata)
    );

    always_comb begin
        above = i_cmd_bus.first_row ? '0 : rb_rdata;
        if (a_rdata == b_rdata) begin
            val = r_diag + CNT_W'(1);
        end else begin
            val = (above > r_left) ? above : r_left;
        end
        total = {1'b0, r_m} + {1'b0, r_n} - {1'b0, r_left};
    end

    always_comb begin
        n_m         = r_m;
        n_n         = r_n;
        n_ovf       = r_ovf;
        n_diag      = r_diag;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        if (we_a) begin
            n_m = r_m + CNT_W'(1);
        end
        if (we_b) begin
            n_n = r_n + CNT_W'(1);
        end
        if (i_cmd_bus.push && ((!i_cmd && a_full) || (i_cmd && b_full))) begin
            n_ovf = 1'b1;
        end
        if (i_cmd_bus.clear) begin
            n_diag = '0;
            n_left = '0;
        end else if (r_cell_v) begin
            n_diag = above;
            n_left = val;
        end
        if (i_cmd_bus.finish) begin
            n_m         = '0;
            n_n         = '0;
            n_ovf       = 1'b0;
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m         <= '0;
            r_n         <= '0;
            r_ovf       <= 1'b0;
            r_cell_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_m         <= n_m;
            r_n         <= n_n;
            r_ovf       <= n_ovf;
            r_cell_v    <= i_cmd_bus.calc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diag <= n_diag;
        r_left <= n_left;
        r_k_d  <= i_cmd_bus.col;
        if (i_cmd_bus.finish) begin
            r_super   <= sat_super(total);
            r_lcs     <= sat_lcs(r_left);
            r_ovf_out <= r_ovf;
        end
    end

    assign o_status.m        = r_m;
    assign o_status.n        = r_n;
    assign o_status.out_busy = r_out_valid;

    assign o_valid        = r_out_valid;
    assign o_super_length = r_super;
    assign o_lcs_length   = r_lcs;
    assign o_overflowed   = r_ovf_out;

endmodule

### rtl/scsl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsl_ctrl
// Controller that sequences loading, the row-by-row table walk and the result.
// ----------------------------------------------------------------------------
module scsl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd,
    input  logic              i_last,
    input  scsl_pkg::t_status i_status,
    output scsl_pkg::t_cmd    o_cmd_bus
);
    import scsl_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_RUN    = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] r_state, n_state;
    t_addr      r_i, n_i;
    t_addr      r_k, n_k;

    logic accept, trigger, last_col, last_row;

    assign o_ready  = (r_state == S_IDLE) && !(i_cmd && i_last && i_status.out_busy);
    assign accept   = i_valid && o_ready;
    assign trigger  = accept && i_cmd && i_last;
    assign last_col = (CNT_W'(r_k) == i_status.n - CNT_W'(1));
    assign last_row = (CNT_W'(r_i) == i_status.m - CNT_W'(1));

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (trigger) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_i = '0;
                if (i_status.m == '0 || i_status.n == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_k     = '0;
                n_state = S_RUN;
            end
            S_RUN: begin
                if (last_col) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                if (last_row) begin
                    n_state = S_FINISH;
                end else begin
                    n_i     = r_i + ADDR_W'(1);
                    n_state = S_FETCH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_k     <= n_k;
        end
    end

    assign o_cmd_bus.push      = accept;
    assign o_cmd_bus.clear     = (r_state == S_START) || (r_state == S_FETCH);
    assign o_cmd_bus.calc      = (r_state == S_RUN);
    assign o_cmd_bus.first_row = (r_i == '0);
    assign o_cmd_bus.finish    = (r_state == S_FINISH);
    assign o_cmd_bus.row       = r_i;
    assign o_cmd_bus.col       = r_k;

    a_trigger_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trigger |=> (r_state == S_START))
        else $error("compute did not start after the final word");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (CNT_W'(r_k) < i_status.n))
        else $error("column index beyond second string length");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (CNT_W'(r_i) < i_status.m))
        else $error("row index beyond first string length");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> !i_status.out_busy)
        else $error("result overwritten before it was taken");

endmodule

### tb/sv/scs_length_via_lcs_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_length_via_lcs_unit_checker
// Watches both channels of the supersequence length unit. Each symbol word
// taken by the unit is applied to a private model of the two string stores.
// The final word of the second string produces an expected supersequence
// length, LCS length and overflow flag. Every result the unit returns is
// compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
package scsl_tb_pkg;

    localparam logic CMD_FIRST  = 1'b0;
    localparam logic CMD_SECOND = 1'b1;

endpackage

module scs_length_via_lcs_unit_checker
    import scsl_pkg::*;
    import scsl_tb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_cmd,
    input  logic [IN_SYM_W-1:0] i_symbol,
    input  logic                i_last,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [SUPER_W-1:0]  i_super_length,
    input  logic [LCS_W-1:0]    i_lcs_length,
    input  logic                i_overflowed,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_results,
    output int                  o_overflow_results
);

    typedef struct packed {
        logic [SUPER_W-1:0] super_len;
        logic [LCS_W-1:0]   lcs_len;
        logic               ovf;
    } t_scs_answer;

    t_sym        first_syms  [MAX_LEN];
    t_sym        second_syms [MAX_LEN];
    int          first_len;
    int          second_len;
    bit          truncated;
    t_scs_answer answers_due [$];

    initial begin
        o_errors           = 0;
        o_pending          = 0;
        o_results          = 0;
        o_overflow_results = 0;
        first_len          = 0;
        second_len         = 0;
        truncated          = 1'b0;
    end

    function automatic int lcs_of_stores();
        int row [MAX_LEN + 1];
        int diag;
        int above;
        int val;
        for (int j = 0; j <= MAX_LEN; j++) begin
            row[j] = 0;
        end
        for (int i = 0; i < first_len; i++) begin
            diag = 0;
            for (int j = 1; j <= second_len; j++) begin
                above = row[j];
                if (first_syms[i] == second_syms[j-1]) begin
                    val = diag + 1;
                end else begin
                    val = (above > row[j-1]) ? above : row[j-1];
                end
                diag   = above;
                row[j] = val;
            end
        end
        return row[second_len];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        o_errors++;
    endtask

    task automatic take_word(input logic cmd, input logic [IN_SYM_W-1:0] sym,
                             input logic last);
        int          lcs;
        int          total;
        t_scs_answer answer;
        if (cmd == CMD_FIRST) begin
            if (first_len < MAX_LEN) begin
                first_syms[first_len] = t_sym'(sym);
                first_len++;
            end else begin
                truncated = 1'b1;
            end
        end else begin
            if (second_len < MAX_LEN) begin
                second_syms[second_len] = t_sym'(sym);
                second_len++;
            end else begin
                truncated = 1'b1;
            end
            if (last) begin
                lcs              = lcs_of_stores();
                total            = first_len + second_len - lcs;
                answer.super_len = SUPER_W'((total > SUPER_MAX) ? SUPER_MAX : total);
                answer.lcs_len   = LCS_W'((lcs > LCS_MAX) ? LCS_MAX : lcs);
                answer.ovf       = truncated;
                answers_due.push_back(answer);
                first_len  = 0;
                second_len = 0;
                truncated  = 1'b0;
            end
        end
    endtask

    task automatic check_result();
        t_scs_answer want;
        if (answers_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: super %0d lcs %0d ovf %0d",
                                      i_super_length, i_lcs_length, i_overflowed));
        end else begin
            want = answers_due.pop_front();
            if (i_super_length !== want.super_len) begin
                report_mismatch($sformatf("super_length got %0d expected %0d",
                                          i_super_length, want.super_len));
            end
            if (i_lcs_length !== want.lcs_len) begin
                report_mismatch($sformatf("lcs_length got %0d expected %0d",
                                          i_lcs_length, want.lcs_len));
            end
            if (i_overflowed !== want.ovf) begin
                report_mismatch($sformatf("overflowed got %0d expected %0d",
                                          i_overflowed, want.ovf));
            end
            if (want.ovf) begin
                o_overflow_results++;
            end
        end
        o_results++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            first_len  = 0;
            second_len = 0;
            truncated  = 1'b0;
            answers_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_in_valid && i_in_ready) begin
                take_word(i_cmd, i_symbol, i_last);
            end
        end
        o_pending = answers_due.size();
    end

endmodule

### tb/sv/scs_length_via_lcs_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_length_via_lcs_unit_tb
// Drives pairs of symbol strings into the supersequence length unit: a short
// directed set of corner cases, then random pairs of mostly short strings
// over narrow and full symbol alphabets, with some full length and
// truncated strings. Both sides stall in random bursts. The checker module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module scs_length_via_lcs_unit_tb;
    import scsl_pkg::*;
    import scsl_tb_pkg::*;

    localparam int WORDS_TARGET = 1600;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 64;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                i_valid  = 1'b0;
    logic                i_cmd    = 1'b0;
    logic [IN_SYM_W-1:0] i_symbol = '0;
    logic                i_last   = 1'b0;
    logic                i_ready  = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [SUPER_W-1:0]  o_super_length;
    logic [LCS_W-1:0]    o_lcs_length;
    logic                o_overflowed;

    int          errors;
    int          pending;
    int          results;
    int          overflow_results;
    int          words_sent   = 0;
    int          pairs_sent   = 0;
    int          ready_hold   = 0;
    int unsigned cycle_count  = 0;
    bit          quiet        = 1'b0;
    bit          calm         = 1'b0;

    scs_length_via_lcs_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_symbol       (i_symbol),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_super_length (o_super_length),
        .o_lcs_length   (o_lcs_length),
        .o_overflowed   (o_overflowed)
    );

    scs_length_via_lcs_unit_checker checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_ready         (o_ready),
        .i_cmd              (i_cmd),
        .i_symbol           (i_symbol),
        .i_last             (i_last),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_super_length     (o_super_length),
        .i_lcs_length       (o_lcs_length),
        .i_overflowed       (o_overflowed),
        .o_errors           (errors),
        .o_pending          (pending),
        .o_results          (results),
        .o_overflow_results (overflow_results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("tb: failure");
            $finish;
        end
    end

    // The result side stalls in random bursts unless calm or quiet.
    always @(negedge i_clk) begin
        if (quiet || calm) begin
            i_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (i_ready) begin
            i_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 12);
        end else begin
            i_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 20);
        end
    end

    task automatic hold_sender(input int cycles);
        @(negedge i_clk);
        i_valid  <= 1'b0;
        i_cmd    <= 1'($urandom);
        i_symbol <= IN_SYM_W'($urandom);
        i_last   <= 1'($urandom);
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic push_word(input logic cmd, input logic [IN_SYM_W-1:0] sym,
                             input logic last);
        if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            hold_sender($urandom_range(1, 13));
        end
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_cmd    <= cmd;
        i_symbol <= sym;
        i_last   <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [IN_SYM_W-1:0] pick_symbol(input logic [IN_SYM_W-1:0] base,
                                                        input int spread);
        if (spread == 0) begin
            return IN_SYM_W'($urandom_range(0, 255));
        end
        return base ^ IN_SYM_W'($urandom_range(0, spread - 1));
    endfunction

    task automatic send_pair(input int m, input int n);
        logic [IN_SYM_W-1:0] base;
        int                  spread;
        logic                last;
        base = IN_SYM_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 2;
            2: spread = 4;
            default: spread = 16;
        endcase
        for (int i = 0; i < m; i++) begin
            last = (i == m - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
            push_word(CMD_FIRST, pick_symbol(base, spread), last);
        end
        for (int j = 0; j < n; j++) begin
            push_word(CMD_SECOND, pick_symbol(base, spread), j == n - 1);
        end
        pairs_sent++;
    endtask

    initial begin
        int seq;
        int kind;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty first string, then single symbols that match and differ.
        push_word(CMD_SECOND, 8'h00, 1'b1);
        push_word(CMD_FIRST, 8'hFF, 1'b1);
        push_word(CMD_SECOND, 8'hFF, 1'b1);
        push_word(CMD_FIRST, 8'h00, 1'b0);
        push_word(CMD_SECOND, 8'hFF, 1'b1);
        // Alternating bit patterns sharing a two symbol subsequence.
        push_word(CMD_FIRST, 8'hAA, 1'b0);
        push_word(CMD_FIRST, 8'h55, 1'b0);
        push_word(CMD_FIRST, 8'hAA, 1'b1);
        push_word(CMD_SECOND, 8'h55, 1'b0);
        push_word(CMD_SECOND, 8'hAA, 1'b0);
        push_word(CMD_SECOND, 8'h55, 1'b1);
        // A last flag inside the first string does not end anything.
        push_word(CMD_FIRST, 8'h01, 1'b1);
        push_word(CMD_FIRST, 8'h02, 1'b1);
        push_word(CMD_SECOND, 8'h02, 1'b0);
        push_word(CMD_SECOND, 8'h01, 1'b1);
        // Repeated symbols against an empty first string.
        push_word(CMD_SECOND, 8'hFF, 1'b0);
        push_word(CMD_SECOND, 8'hFF, 1'b0);
        push_word(CMD_SECOND, 8'hFF, 1'b0);
        push_word(CMD_SECOND, 8'hFF, 1'b1);
        wait_drained();

        seq = 0;
        while (words_sent < WORDS_TARGET) begin
            if (words_sent >= WORDS_TARGET * 9 / 10) begin
                quiet <= 1'b1;
            end
            calm <= ($urandom_range(0, 7) == 0);
            if (!quiet && $urandom_range(0, 24) == 0) begin
                wait_drained();
            end
            kind = (seq < 4) ? seq : 4;
            case (kind)
                0: send_pair(MAX_LEN + $urandom_range(1, 10), $urandom_range(1, 8));
                1: send_pair($urandom_range(1, 8), MAX_LEN + $urandom_range(1, 10));
                2: send_pair(MAX_LEN, MAX_LEN);
                3: send_pair(MAX_LEN + $urandom_range(1, 5), MAX_LEN + $urandom_range(1, 5));
                default: begin
                    case ($urandom_range(0, 99)) inside
                        [0:1]:   send_pair($urandom_range(100, 140), $urandom_range(100, 140));
                        [2:9]:   send_pair(0, $urandom_range(1, 12));
                        [10:17]: send_pair($urandom_range(13, 40), $urandom_range(1, 40));
                        default: send_pair($urandom_range(0, 12), $urandom_range(1, 12));
                    endcase
                end
            endcase
            seq++;
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d symbol words in %0d string pairs over %0d cycles.",
                 words_sent, pairs_sent, cycle_count);
        $display("Checked %0d supersequence results, %0d of them with truncated strings.",
                 results, overflow_results);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### scs_length_via_lcs_unit.f
rtl/scsl_pkg.sv
rtl/scsl_ram.sv
rtl/scsl_datapath.sv
rtl/scsl_ctrl.sv
rtl/scs_length_via_lcs_unit.sv
tb/sv/scs_length_via_lcs_unit_checker.sv
tb/sv/scs_length_via_lcs_unit_tb.sv
